// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL; included by the controller (rsfd_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RSFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define RSFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== hdl/rsfd_pkg.sv =====
// Types, constants and codes of the random storage fault decider.
package rsfd_pkg;

   localparam int COUNT_W   = 32;
   localparam int STATE_W   = 64;
   localparam int HALF_W    = STATE_W / 2;
   localparam int RATE_W    = 54;
   localparam int DRAW_DROP = 11;
   localparam int CSR_IDX_W = 8;

   localparam int MIX_SHIFT_0 = 30;
   localparam int MIX_SHIFT_1 = 27;
   localparam int MIX_SHIFT_2 = 31;

   localparam logic [STATE_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [STATE_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [STATE_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED          = 8'd0,
      CSR_SYNC_RATE     = 8'd1,
      CSR_WR_FAULT_RATE = 8'd2,
      CSR_PARTIAL_RATE  = 8'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_PASS    = 2'd0,
      VERDICT_FAIL    = 2'd1,
      VERDICT_PARTIAL = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      TRIAL_SYNC,
      TRIAL_WRITE,
      TRIAL_TRUNC
   } trial_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_ADVANCE,
      DP_MUL_A,
      DP_MIX_A,
      DP_MUL_B,
      DP_MIX_B,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      trial_type   trial;
      verdict_type verdict;
   } dp_cmd_type;

   typedef struct packed {
      logic operation;
      logic count_gt1;
      logic rate_zero;
      logic rate_full;
      logic fire;
      logic mul_done;
   } dp_status_type;

endpackage

// ===== hdl/rsfd_channels_if.sv =====
// Handshake channel interfaces: request, response and register write.
interface rsfd_req_if import rsfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [COUNT_W-1:0] byte_count;

   modport source (output valid, operation, byte_count, input ready);
   modport sink   (input valid, operation, byte_count, output ready);
endinterface

interface rsfd_rsp_if import rsfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         verdict;
   logic [COUNT_W-1:0] forward_count;

   modport source (output valid, verdict, forward_count, input ready);
   modport sink   (input valid, verdict, forward_count, output ready);
endinterface

interface rsfd_csr_if import rsfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [STATE_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/random_storage_fault_decider.sv =====
// Top level of the random storage fault decider: channels, controller and datapath.
// A trial whose rate is zero or full scale settles without a draw; any other trial takes one
// draw, which runs two chained 64-bit multiplies on the shared 32x32 multiplier. A faulting
// write adds a truncation trial. A new request is taken only after the previous response
// has been registered.
// Reset (synchronous, active high) clears generator state, rates and control at once.
module random_storage_fault_decider import rsfd_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   rsfd_req_if.sink   req_chan,
   rsfd_rsp_if.source rsp_chan,
   rsfd_csr_if.sink   csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   // Register writes are always taken; they load the datapath directly.
   // A seed write replaces the generator state; rate writes keep 54 bits.
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   // Controller: one request transaction at a time. Ready only in its idle
   // state; a finished response sits in the output registers, so the next
   // request is taken while that response still waits for the sink.
   rsfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: SplitMix64 state, mixing steps, rate compare and the
   // response registers (verdict and forwarded byte count).
   rsfd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_chan.operation),
      .req_byte_count    (req_chan.byte_count),
      .csr_write         (csr_write),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .cmd               (cmd),
      .status            (status),
      .rsp_verdict       (rsp_chan.verdict),
      .rsp_forward_count (rsp_chan.forward_count)
   );

endmodule

// ===== hdl/rsfd_mul.sv =====
// Iterative 64x64 low-half multiplier built on one 32x32 multiplier.
module rsfd_mul import rsfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [STATE_W-1:0] a_data,
   input  logic [STATE_W-1:0] b_data,
   output logic               done,
   output logic [STATE_W-1:0] product
);

   typedef enum logic [1:0] {
      PH_LL,
      PH_LH,
      PH_HL,
      PH_ACC
   } phase_type;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   phase_type          phase_ff, phase_in;
   logic [STATE_W-1:0] a_ff, a_in;
   logic [STATE_W-1:0] b_ff, b_in;
   logic [STATE_W-1:0] prod_ff, prod_in;
   logic [STATE_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]  mul_x, mul_y;

   // partial product order: lo*lo, lo(a)*hi(b), hi(a)*lo(b)
   always_comb begin
      mul_x   = (phase_ff == PH_HL) ? a_ff[STATE_W-1:HALF_W] : a_ff[HALF_W-1:0];
      mul_y   = (phase_ff == PH_LH) ? b_ff[STATE_W-1:HALF_W] : b_ff[HALF_W-1:0];
      prod_in = STATE_W'(mul_x) * STATE_W'(mul_y);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_LL;
         a_in     = a_data;
         b_in     = b_data;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_LL: begin
               phase_in = PH_LH;
            end
            PH_LH: begin
               acc_in   = prod_ff;
               phase_in = PH_HL;
            end
            PH_HL: begin
               acc_in   = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = PH_ACC;
            end
            default: begin
               acc_in   = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = PH_LL;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hdl/rsfd_dpath.sv =====
// Datapath: generator state, rate registers, mixing steps and result registers.
module rsfd_dpath import rsfd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_operation,
   input  logic [COUNT_W-1:0]   req_byte_count,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STATE_W-1:0]   csr_data,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic [1:0]           rsp_verdict,
   output logic [COUNT_W-1:0]   rsp_forward_count
);

   logic [STATE_W-1:0] state_ff, state_in;
   logic [STATE_W-1:0] z_ff, z_in;
   logic [RATE_W-1:0]  sync_rate_ff, sync_rate_in;
   logic [RATE_W-1:0]  wr_fault_rate_ff, wr_fault_rate_in;
   logic [RATE_W-1:0]  partial_rate_ff, partial_rate_in;
   logic               operation_ff, operation_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         verdict_ff, verdict_in;
   logic [COUNT_W-1:0] fwd_ff, fwd_in;

   logic [STATE_W-1:0] advanced;
   logic [STATE_W-1:0] mul_product;
   logic               mul_done;
   logic               mul_start;
   logic [STATE_W-1:0] mul_const;
   logic [RATE_W-1:0]  sel_rate;

   assign mul_start = (cmd.op == DP_MUL_A) || (cmd.op == DP_MUL_B);
   assign mul_const = (cmd.op == DP_MUL_B) ? MIX_MUL_B : MIX_MUL_A;

   rsfd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_data  (z_ff),
      .b_data  (mul_const),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      case (cmd.trial)
         TRIAL_SYNC:  sel_rate = sync_rate_ff;
         TRIAL_WRITE: sel_rate = wr_fault_rate_ff;
         default:     sel_rate = partial_rate_ff;
      endcase
   end

   // top 53 bits of the mixed word against the selected rate
   always_comb begin
      status.operation = operation_ff;
      status.count_gt1 = |count_ff[COUNT_W-1:1];
      status.rate_zero = (sel_rate == '0);
      status.rate_full = sel_rate[RATE_W-1];
      status.fire      = {1'b0, z_ff[STATE_W-1:DRAW_DROP]} < sel_rate;
      status.mul_done  = mul_done;
   end

   assign advanced = state_ff + GOLDEN_STEP;

   always_comb begin
      state_in         = state_ff;
      z_in             = z_ff;
      sync_rate_in     = sync_rate_ff;
      wr_fault_rate_in = wr_fault_rate_ff;
      partial_rate_in  = partial_rate_ff;
      operation_in     = operation_ff;
      count_in         = count_ff;
      verdict_in       = verdict_ff;
      fwd_in           = fwd_ff;

      case (cmd.op)
         DP_LOAD: begin
            operation_in = req_operation;
            count_in     = req_byte_count;
         end
         DP_ADVANCE: begin
            state_in = advanced;
            z_in     = advanced ^ (advanced >> MIX_SHIFT_0);
         end
         DP_MIX_A: begin
            z_in = mul_product ^ (mul_product >> MIX_SHIFT_1);
         end
         DP_MIX_B: begin
            z_in = mul_product ^ (mul_product >> MIX_SHIFT_2);
         end
         DP_RESULT: begin
            verdict_in = cmd.verdict;
            case (cmd.verdict)
               VERDICT_PASS:    fwd_in = operation_ff ? count_ff : '0;
               VERDICT_PARTIAL: fwd_in = count_ff >> 1;
               default:         fwd_in = '0;
            endcase
         end
         default: begin
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_write) begin
         case (csr_index)
            CSR_SEED:          state_in         = csr_data;
            CSR_SYNC_RATE:     sync_rate_in     = csr_data[RATE_W-1:0];
            CSR_WR_FAULT_RATE: wr_fault_rate_in = csr_data[RATE_W-1:0];
            CSR_PARTIAL_RATE:  partial_rate_in  = csr_data[RATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '0;
         sync_rate_ff     <= '0;
         wr_fault_rate_ff <= '0;
         partial_rate_ff  <= '0;
      end else begin
         state_ff         <= state_in;
         sync_rate_ff     <= sync_rate_in;
         wr_fault_rate_ff <= wr_fault_rate_in;
         partial_rate_ff  <= partial_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff         <= z_in;
      operation_ff <= operation_in;
      count_ff     <= count_in;
      verdict_ff   <= verdict_in;
      fwd_ff       <= fwd_in;
   end

   assign rsp_verdict       = verdict_ff;
   assign rsp_forward_count = fwd_ff;

endmodule

// ===== hdl/rsfd_ctrl.sv =====
// Controller: sequences trials and draws, resolves the verdict, owns handshakes.
`include "assert_macros.svh"

module rsfd_ctrl import rsfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_DECIDE,
      S_ADVANCE,
      S_MUL_A,
      S_WAIT_A,
      S_MUL_B,
      S_WAIT_B,
      S_CMP,
      S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   trial_type   trial_ff, trial_in;
   verdict_type verdict_ff, verdict_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        resolve;
   logic        outcome;
   logic        in_mul_wait;
   logic        trunc_active;
   logic        emit_pending;
   logic        ctrl_idle;

   always_comb begin
      state_in     = state_ff;
      trial_in     = trial_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = DP_NOP;
      cmd.trial    = trial_ff;
      cmd.verdict  = verdict_ff;
      resolve      = 1'b0;
      outcome      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            trial_in = status.operation ? TRIAL_WRITE : TRIAL_SYNC;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // extreme rates settle without a draw
            if (status.rate_zero || status.rate_full) begin
               resolve = 1'b1;
               outcome = status.rate_full;
            end else begin
               state_in = S_ADVANCE;
            end
         end
         S_ADVANCE: begin
            cmd.op   = DP_ADVANCE;
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            cmd.op   = DP_MUL_A;
            state_in = S_WAIT_A;
         end
         S_WAIT_A: begin
            if (status.mul_done) begin
               cmd.op   = DP_MIX_A;
               state_in = S_MUL_B;
            end
         end
         S_MUL_B: begin
            cmd.op   = DP_MUL_B;
            state_in = S_WAIT_B;
         end
         S_WAIT_B: begin
            if (status.mul_done) begin
               cmd.op   = DP_MIX_B;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            resolve = 1'b1;
            outcome = status.fire;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (resolve) begin
         case (trial_ff)
            TRIAL_SYNC: begin
               verdict_in = outcome ? VERDICT_FAIL : VERDICT_PASS;
               state_in   = S_EMIT;
            end
            TRIAL_WRITE: begin
               if (outcome) begin
                  trial_in = TRIAL_TRUNC;
                  state_in = S_DECIDE;
               end else begin
                  verdict_in = VERDICT_PASS;
                  state_in   = S_EMIT;
               end
            end
            default: begin
               verdict_in = (outcome && status.count_gt1) ? VERDICT_PARTIAL : VERDICT_FAIL;
               state_in   = S_EMIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trial_ff     <= TRIAL_SYNC;
         verdict_ff   <= VERDICT_PASS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trial_ff     <= trial_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign in_mul_wait  = (state_ff == S_WAIT_A) || (state_ff == S_WAIT_B);
   assign trunc_active = (trial_ff == TRIAL_TRUNC) && (state_ff != S_IDLE)
                         && (state_ff != S_START);
   assign emit_pending = (state_ff == S_EMIT) && rsp_valid_ff;
   assign ctrl_idle    = (state_ff == S_IDLE) && !rsp_valid_ff;

   `RSFD_ASSERT(a_mul_done_in_wait, status.mul_done |-> in_mul_wait, "multiplier done outside wait")
   `RSFD_ASSERT(a_trunc_only_write, trunc_active |-> status.operation, "truncation trial on a sync")
   `RSFD_ASSERT(a_emit_holds, (emit_pending && !rsp_ready) |=> emit_pending, "pending response lost")
   `RSFD_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> ctrl_idle, "controller not idle after reset")

endmodule

// ===== tb/random_storage_fault_decider_tb.sv =====
// Self-checking regression for the random storage fault decider: directed and random traffic.
module random_storage_fault_decider_tb;
   import rsfd_pkg::*;

   // Operation codes on the request channel.
   localparam logic OP_SYNC  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes that map to nothing; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 8'hff;

   // Rates are fractions of 2^53 held in a 54-bit field.
   localparam logic [RATE_W-1:0] RATE_FULL = 54'h20_0000_0000_0000;
   localparam logic [RATE_W-1:0] RATE_MASK = {RATE_W{1'b1}};

   // Limit covers the worst-case transaction time plus stalls on both sides.
   localparam int CYCLE_LIMIT = 400000;
   // Settle time after the last response.
   localparam int SETTLE_CYCLES = 32;

   typedef struct {
      verdict_type        verdict;
      logic [COUNT_W-1:0] forward_count;
   } fault_outcome_type;

   logic clock;
   logic reset;

   rsfd_req_if req_chan ();
   rsfd_rsp_if rsp_chan ();
   rsfd_csr_if csr_chan ();

   random_storage_fault_decider dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor copy of the generator and rate registers.
   logic [STATE_W-1:0] gen_state;
   logic [RATE_W-1:0]  sync_rate;
   logic [RATE_W-1:0]  wr_fault_rate;
   logic [RATE_W-1:0]  partial_rate;

   fault_outcome_type outcomes_due[$];

   int  accepted_count = 0;   // request transactions the sender saw accepted
   int  results_checked = 0;  // responses matched against a prediction
   int  error_count = 0;
   int  cycle_count = 0;
   int  sync_seen = 0;
   int  write_seen = 0;
   int  draws_taken = 0;
   int  csr_writes = 0;
   int  pass_seen = 0;
   int  fail_seen = 0;
   int  partial_seen = 0;

   // Shared knobs between test tasks, the request driver and the response sink.
   bit  idle_on = 1'b1;
   int  hold_request = 0;
   bit  holding_now = 1'b0;
   bit  req_up = 1'b0;        // request valid currently driven high

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // One SplitMix64 step; returns the top 53 bits of the mixed state.
   function automatic logic [STATE_W-1:0] next_draw();
      logic [STATE_W-1:0] z;
      gen_state = gen_state + GOLDEN_STEP;
      z = gen_state;
      z = (z ^ (z >> MIX_SHIFT_0)) * MIX_MUL_A;
      z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MUL_B;
      z = z ^ (z >> MIX_SHIFT_2);
      draws_taken++;
      return z >> DRAW_DROP;
   endfunction

   // Bernoulli trial; zero and full-scale (or above) rates skip the draw.
   function automatic bit trial_fires(input logic [RATE_W-1:0] rate);
      if (rate == '0)
         return 1'b0;
      if (rate >= RATE_FULL)
         return 1'b1;
      return next_draw() < {{(STATE_W-RATE_W){1'b0}}, rate};
   endfunction

   function automatic fault_outcome_type decide_event(input logic op,
                                                      input logic [COUNT_W-1:0] count);
      fault_outcome_type r;
      bit cut;
      if (op == OP_SYNC) begin
         r.verdict = trial_fires(sync_rate) ? VERDICT_FAIL : VERDICT_PASS;
         r.forward_count = '0;
      end else if (trial_fires(wr_fault_rate)) begin
         // truncation draw is taken even for tiny counts
         cut = trial_fires(partial_rate);
         if (cut && count > 1) begin
            r.verdict = VERDICT_PARTIAL;
            r.forward_count = count >> 1;
         end else begin
            r.verdict = VERDICT_FAIL;
            r.forward_count = '0;
         end
      end else begin
         r.verdict = VERDICT_PASS;
         r.forward_count = count;
      end
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [STATE_W-1:0] value);
      case (idx)
         CSR_SEED:          gen_state     = value;
         CSR_SYNC_RATE:     sync_rate     = value[RATE_W-1:0];
         CSR_WR_FAULT_RATE: wr_fault_rate = value[RATE_W-1:0];
         CSR_PARTIAL_RATE:  partial_rate  = value[RATE_W-1:0];
         default: ;  // unmapped index, dropped
      endcase
   endfunction

   // Transaction monitor on the input side: register writes and requests.
   always @(posedge clock) begin : input_monitor
      if (reset) begin
         gen_state     = '0;
         sync_rate     = '0;
         wr_fault_rate = '0;
         partial_rate  = '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            apply_register(csr_chan.index, csr_chan.data);
            csr_writes++;
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.operation == OP_SYNC)
               sync_seen++;
            else
               write_seen++;
            outcomes_due.push_back(decide_event(req_chan.operation, req_chan.byte_count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : verdict_checker
      fault_outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: unexpected response, verdict %0d forward_count %0d",
                     $time, rsp_chan.verdict, rsp_chan.forward_count);
            error_count++;
         end else begin
            want = outcomes_due.pop_front();
            results_checked++;
            case (want.verdict)
               VERDICT_PASS:    pass_seen++;
               VERDICT_FAIL:    fail_seen++;
               VERDICT_PARTIAL: partial_seen++;
               default: ;
            endcase
            if (rsp_chan.verdict !== want.verdict) begin
               $display("%0t: verdict mismatch, expected %0d actual %0d",
                        $time, want.verdict, rsp_chan.verdict);
               error_count++;
            end
            if (rsp_chan.forward_count !== want.forward_count) begin
               $display("%0t: forward_count mismatch, expected %0d actual %0d",
                        $time, want.forward_count, rsp_chan.forward_count);
               error_count++;
            end
         end
      end
   end

   // Response sink: random ready bursts, plus a long hold-off on request.
   initial begin : response_sink
      int run;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            run = 0;
            rsp_chan.ready <= 1'b0;
            holding_now = 1'b1;
            while (run < hold_request) begin
               @(posedge clock);
               run++;
            end
            hold_request = 0;
            holding_now = 1'b0;
         end else if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, accepted_count - results_checked);
      $display("random_storage_fault_decider regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one request; valid stays up afterwards unless an idle gap follows.
   task automatic send_item(input logic op, input logic [COUNT_W-1:0] count);
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.byte_count <= count;
      req_up = 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      accepted_count++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Register write; csr valid is left high so back-to-back writes stream.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [STATE_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
   endtask

   task automatic end_writes();
      csr_chan.valid <= 1'b0;
   endtask

   // Stop offering and wait for every outstanding response.
   task automatic wait_for_results();
      if (req_up) begin
         req_chan.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (results_checked < accepted_count)
         @(posedge clock);
   endtask

   // Rate picker biased toward the corners; junk above bit 53 is sometimes set.
   function automatic logic [STATE_W-1:0] pick_rate();
      logic [STATE_W-1:0] raw;
      logic [9:0]         junk;
      raw  = {$urandom, $urandom};
      junk = $urandom_range(0, 1) ? raw[63:54] : 10'd0;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {10'd0, RATE_FULL};
         2: return {junk, RATE_MASK};
         3: return 64'd1;
         4: return {10'd0, RATE_FULL - 54'd1};
         default: return {junk, 1'b0, raw[52:0]};
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 3);
         2:       return {COUNT_W{1'b1}};
         3:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic program_random_settings();
      logic [STATE_W-1:0] seed;
      case ($urandom_range(0, 5))
         0:       seed = '0;
         1:       seed = {STATE_W{1'b1}};
         default: seed = {$urandom, $urandom};
      endcase
      write_reg(CSR_SEED, seed);
      write_reg(CSR_SYNC_RATE, pick_rate());
      write_reg(CSR_WR_FAULT_RATE, pick_rate());
      write_reg(CSR_PARTIAL_RATE, pick_rate());
      end_writes();
   endtask

   task automatic send_random_item();
      send_item($urandom_range(0, 1) ? OP_WRITE : OP_SYNC, pick_count());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // All rates reset to zero: everything passes and no draw is taken.
   task automatic test_reset_defaults();
      send_item(OP_SYNC, {COUNT_W{1'b1}});
      send_item(OP_WRITE, '0);
      send_item(OP_WRITE, {COUNT_W{1'b1}});
      send_item(OP_WRITE, 32'h5555_aaaa);
      wait_for_results();
   endtask

   // Corner rates: always-fire, above full scale, masked-off junk bits,
   // small counts under truncation, unmapped register indexes.
   task automatic test_directed_rates();
      write_reg(CSR_SEED, {STATE_W{1'b1}});
      write_reg(CSR_SYNC_RATE, {10'd0, RATE_FULL});
      write_reg(CSR_WR_FAULT_RATE, {10'h3ff, RATE_MASK});
      write_reg(CSR_PARTIAL_RATE, {10'h3ff, RATE_FULL});
      write_reg(CSR_UNUSED_LOW, 64'h0123_4567_89ab_cdef);
      write_reg(CSR_UNUSED_HIGH, '0);
      end_writes();
      send_item(OP_SYNC, 32'h1234_5678);
      send_item(OP_WRITE, 32'd0);              // truncation fires, count too small
      send_item(OP_WRITE, 32'd1);
      send_item(OP_WRITE, 32'd2);              // partial, one byte forwarded
      send_item(OP_WRITE, 32'd3);
      send_item(OP_WRITE, {COUNT_W{1'b1}});
      wait_for_results();

      // junk above the rate field only: truncation rate becomes zero
      write_reg(CSR_PARTIAL_RATE, 64'hffc0_0000_0000_0000);
      end_writes();
      send_item(OP_WRITE, 32'd5);
      send_item(OP_SYNC, 32'd0);
      wait_for_results();

      // smallest nonzero and largest sub-unity rates, zero seed
      write_reg(CSR_SEED, '0);
      write_reg(CSR_SYNC_RATE, {10'd0, RATE_FULL - 54'd1});
      write_reg(CSR_WR_FAULT_RATE, 64'd1);
      write_reg(CSR_PARTIAL_RATE, {10'd0, RATE_FULL - 54'd1});
      end_writes();
      send_item(OP_SYNC, 32'd0);
      send_item(OP_WRITE, 32'd100);
      send_item(OP_WRITE, {COUNT_W{1'b1}});
      send_item(OP_SYNC, {COUNT_W{1'b1}});
      wait_for_results();
   endtask

   // Random settings per phase; idling switched per phase for quiet stretches.
   task automatic test_random_phases(input int n_phases, input int per_phase);
      for (int p = 0; p < n_phases; p++) begin
         wait_for_results();
         idle_on = ($urandom_range(0, 3) != 0);
         program_random_settings();
         for (int i = 0; i < per_phase; i++)
            send_random_item();
      end
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // Sink holds off long while the source keeps offering, so input stalls.
   task automatic test_backpressure();
      wait_for_results();
      write_reg(CSR_SYNC_RATE, pick_rate());
      write_reg(CSR_WR_FAULT_RATE, {10'd0, RATE_FULL >> 1});
      write_reg(CSR_PARTIAL_RATE, {10'd0, RATE_FULL >> 1});
      end_writes();
      hold_request = 150;
      wait (holding_now);
      for (int i = 0; i < 20; i++)
         send_random_item();
      wait_for_results();
   endtask

   // Source pauses mid-stream until the pipeline is empty, then resumes.
   task automatic test_sender_pause();
      for (int i = 0; i < 10; i++)
         send_random_item();
      wait_for_results();
      for (int i = 0; i < 10; i++)
         send_random_item();
      wait_for_results();
   endtask

   // Closing stretch at full rate: no idling on either side.
   task automatic test_full_rate();
      wait_for_results();
      idle_on = 1'b0;
      program_random_settings();
      for (int i = 0; i < 70; i++)
         send_random_item();
      wait_for_results();
   endtask

   initial begin : regression
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.operation  <= OP_SYNC;
      req_chan.byte_count <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= CSR_SEED;
      csr_chan.data       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_rates();
      test_random_phases(4, 65);
      test_backpressure();
      test_sender_pause();
      test_random_phases(4, 65);
      test_full_rate();

      // let any stray response show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (outcomes_due.size() != 0) begin
         $display("%0t: %0d predicted responses never arrived", $time, outcomes_due.size());
         error_count++;
      end

      $display("covered %0d sync and %0d write transactions, %0d register writes, %0d draws",
               sync_seen, write_seen, csr_writes, draws_taken);
      $display("verdicts checked: %0d pass, %0d fail, %0d partial; %0d mismatches",
               pass_seen, fail_seen, partial_seen, error_count);
      if (error_count == 0) begin
         $display("random_storage_fault_decider regression: pass");
      end else begin
         $display("random_storage_fault_decider regression: fail");
      end
      $finish;
   end

endmodule
